/* rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers for the timer table RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that one condition implies another in the next cycle.
`define ASSERT_NEXT(label, clk, rst, cond, res, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (res)) else $error(msg);

`endif

/* rtl/dtt_pkg.sv */
// ---------------------------------------------------------------------------
// dtt_pkg
// Types, constants and codes shared by the timer table modules.
// ---------------------------------------------------------------------------
package dtt_pkg;

   localparam int SLOTS       = 16;
   localparam int SLOT_BITS   = $clog2(SLOTS);
   localparam int PERIOD_BITS = 32;
   localparam int TIME_BITS   = 48;
   localparam logic [TIME_BITS-1:0] TMAX = '1;
   localparam int MAX_RESULTS = 16;
   localparam int CNT_BITS    = $clog2(MAX_RESULTS + 1);

   typedef enum logic [2:0] {
      OP_ADD     = 3'd0,
      OP_CANCEL  = 3'd1,
      OP_RESET   = 3'd2,
      OP_REFRESH = 3'd3,
      OP_QUERY   = 3'd4,
      OP_COLLECT = 3'd5,
      OP_RSVD6   = 3'd6,
      OP_RSVD7   = 3'd7
   } op_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_UNARMED = 2'd1,
      ST_EXPIRED = 2'd2,
      ST_NONE    = 2'd3
   } status_type;

   typedef struct packed {
      logic [2:0]  operation;
      logic [3:0]  slot;
      logic [31:0] period_ms;
      logic        repeat_flag;
      logic        start_at_now;
      logic [47:0] now_ms;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [3:0]  slot_out;
      logic [47:0] wait_ms;
      logic        front_changed;
      logic        any_pending;
      logic        last;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_SCAN,
      S_EMIT,
      S_RESP
   } state_type;

   // control from the sequencer to the scan unit
   typedef struct packed {
      logic                 start;
      logic                 expired_only;
   } scan_ctl_type;

   // result of one scan pass
   typedef struct packed {
      logic                 done;
      logic                 found;
      logic [SLOT_BITS-1:0] best;
   } scan_res_type;

   function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0] a,
                                                    input logic [PERIOD_BITS-1:0] b);
      logic [TIME_BITS:0] s;
      s = {1'b0, a} + {{(TIME_BITS + 1 - PERIOD_BITS){1'b0}}, b};
      return s[TIME_BITS] ? TMAX : s[TIME_BITS-1:0];
   endfunction

endpackage

/* rtl/dtt_scan.sv */
// ---------------------------------------------------------------------------
// dtt_scan
// Walk all slots one per cycle and keep the earliest eligible deadline (only due slots in expired-only mode).
// ---------------------------------------------------------------------------
module dtt_scan import dtt_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  scan_ctl_type                  ctl,
   input  logic [SLOTS-1:0]              eligible,
   input  logic [TIME_BITS-1:0]          now_ms,
   output logic [SLOT_BITS-1:0]          rd_idx,
   input  logic [TIME_BITS-1:0]          rd_deadline,
   output scan_res_type                  res
);

   logic                 busy_ff, busy_in;
   logic [SLOT_BITS-1:0] idx_ff, idx_in;
   logic                 found_ff, found_in;
   logic [SLOT_BITS-1:0] best_ff, best_in;
   logic [TIME_BITS-1:0] best_dl_ff, best_dl_in;
   logic                 exp_ff, exp_in;
   logic                 done_ff, done_in;
   logic                 take;

   assign rd_idx = idx_ff;

   always_comb begin
      busy_in    = busy_ff;
      idx_in     = idx_ff;
      found_in   = found_ff;
      best_in    = best_ff;
      best_dl_in = best_dl_ff;
      exp_in     = exp_ff;
      done_in    = 1'b0;
      // strict less keeps the lower slot on ties
      take = eligible[idx_ff] && (!exp_ff || rd_deadline <= now_ms)
             && (!found_ff || rd_deadline < best_dl_ff);
      if (ctl.start) begin
         busy_in  = 1'b1;
         idx_in   = '0;
         found_in = 1'b0;
         exp_in   = ctl.expired_only;
      end else if (busy_ff) begin
         if (take) begin
            found_in   = 1'b1;
            best_in    = idx_ff;
            best_dl_in = rd_deadline;
         end
         if (idx_ff == SLOT_BITS'(SLOTS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            idx_in = idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         found_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         found_ff <= found_in;
         idx_ff   <= idx_in;
      end
      best_ff    <= best_in;
      best_dl_ff <= best_dl_in;
      exp_ff     <= exp_in;
   end

   assign res.done  = done_ff;
   assign res.found = found_ff;
   assign res.best  = best_ff;

endmodule

/* rtl/deadline_timer_table.sv */
// ---------------------------------------------------------------------------
// deadline_timer_table
// Table of timer slots with add, cancel, reset, refresh, query and collect.
// ---------------------------------------------------------------------------
// Add/cancel/reset/refresh/query run one serial scan over the slot table for the
//   earliest deadline before the response; a bad slot or unknown op skips it.
// Collect: (k + 1) scans for k expired slots, or k scans when k reaches MAX_RESULTS.
// Requests: one item at a time; req_stall holds a new item off until idle.
// Reset: synchronous, clears all armed bits and the sequencer; slot data
//   holds whatever it had.
module deadline_timer_table import dtt_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

`include "assert_macros.svh"

   // slot state
   logic [SLOTS-1:0]       armed_ff, armed_in;
   logic [TIME_BITS-1:0]   deadline_ff [SLOTS];
   logic [PERIOD_BITS-1:0] interval_ff [SLOTS];
   logic [SLOTS-1:0]       recurring_ff;

   state_type state_ff, state_in;
   req_type   req_ff;
   rsp_type   rsp_ff, rsp_in;
   logic      rsp_valid_ff, rsp_valid_in;

   logic [SLOTS-1:0]     taken_ff, taken_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic                 pend_ff, pend_in;   // a found slot waits to be emitted
   logic [SLOT_BITS-1:0] pend_slot_ff, pend_slot_in;
   logic                 wrote_ff, wrote_in;
   logic [1:0]           st_ff, st_in;
   logic                 keep_ff, keep_in;   // some slot stays armed after collect

   scan_ctl_type         scan_ctl;
   scan_res_type         scan_res;
   logic [SLOT_BITS-1:0] scan_idx;
   logic [SLOTS-1:0]     eligible;

   logic                 in_acc, out_acc;
   logic [SLOT_BITS-1:0] si;
   logic                 slot_ok;
   logic [TIME_BITS-1:0] old_start;
   logic [PERIOD_BITS-1:0] per;

   assign in_acc  = req_valid && !req_stall;
   assign out_acc = rsp_valid_ff && !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign si      = req_ff.slot[SLOT_BITS-1:0];
   assign slot_ok = ({1'b0, req_ff.slot} < 5'(SLOTS));
   assign per     = req_ff.period_ms[PERIOD_BITS-1:0];
   assign old_start = (deadline_ff[si] >= TIME_BITS'(interval_ff[si]))
                      ? deadline_ff[si] - TIME_BITS'(interval_ff[si]) : '0;

   assign eligible = armed_ff & ~taken_ff;

   dtt_scan u_scan (
      .clock       (clock),
      .reset       (reset),
      .ctl         (scan_ctl),
      .eligible    (eligible),
      .now_ms      (req_ff.now_ms),
      .rd_idx      (scan_idx),
      .rd_deadline (deadline_ff[scan_idx]),
      .res         (scan_res)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (in_acc) state_in = S_EXEC;
         S_EXEC: begin
            if (req_ff.operation > OP_COLLECT || (req_ff.operation <= OP_REFRESH && !slot_ok))
               state_in = S_RESP;
            else
               state_in = S_SCAN;
         end
         S_SCAN: if (scan_res.done) state_in = S_EMIT;
         S_EMIT: begin
            // collect loops back to scan until no expired slot remains or the result limit is reached
            if (req_ff.operation == OP_COLLECT && scan_res.found
                && cnt_ff < CNT_BITS'(MAX_RESULTS - 1))
               state_in = (!rsp_valid_ff || out_acc) ? S_SCAN : S_EMIT;
            else
               state_in = (!rsp_valid_ff || out_acc) ? S_RESP : S_EMIT;
         end
         S_RESP: if (!rsp_valid_ff || out_acc) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      armed_in     = armed_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !out_acc;
      taken_in     = taken_ff;
      cnt_in       = cnt_ff;
      pend_in      = pend_ff;
      pend_slot_in = pend_slot_ff;
      wrote_in     = wrote_ff;
      st_in        = st_ff;
      keep_in      = keep_ff;
      scan_ctl     = '0;
      unique case (state_ff)
         S_IDLE: begin
            taken_in = '0;
            cnt_in   = '0;
            pend_in  = 1'b0;
            wrote_in = 1'b0;
            keep_in  = 1'b0;
            st_in    = ST_OK;
         end
         S_EXEC: begin
            scan_ctl.start        = 1'b1;
            scan_ctl.expired_only = (req_ff.operation == OP_COLLECT);
            if (req_ff.operation <= OP_REFRESH && slot_ok) begin
               unique case (op_type'(req_ff.operation))
                  OP_ADD: begin
                     armed_in[si] = 1'b1;
                     wrote_in     = 1'b1;
                  end
                  OP_CANCEL: begin
                     if (armed_ff[si]) armed_in[si] = 1'b0;
                     else st_in = ST_UNARMED;
                  end
                  OP_RESET: begin
                     if (!armed_ff[si]) st_in = ST_UNARMED;
                     else wrote_in = 1'b1;
                  end
                  default: begin
                     armed_in[si] = recurring_ff[si];
                     wrote_in     = recurring_ff[si];
                  end
               endcase
            end
         end
         S_SCAN: begin
            // a slot survives collect if it is recurring or not yet due
            keep_in = keep_ff | (armed_ff[scan_idx] && (recurring_ff[scan_idx]
                      || deadline_ff[scan_idx] > req_ff.now_ms));
         end
         S_EMIT: begin
            if (!rsp_valid_ff || out_acc) begin
               if (req_ff.operation == OP_COLLECT && scan_res.found) begin
                  // another expired slot follows, so the held one is not last
                  if (pend_ff) begin
                     rsp_in = '0;
                     rsp_in.status   = ST_EXPIRED;
                     rsp_in.slot_out = 4'(pend_slot_ff);
                     rsp_in.last     = 1'b0;
                     rsp_valid_in    = 1'b1;
                     rsp_in.any_pending = keep_ff;
                  end
                  pend_in      = 1'b1;
                  pend_slot_in = scan_res.best;
                  taken_in[scan_res.best] = 1'b1;
                  cnt_in = cnt_ff + 1'b1;
                  if (cnt_ff < CNT_BITS'(MAX_RESULTS - 1)) begin
                     scan_ctl.start        = 1'b1;
                     scan_ctl.expired_only = 1'b1;
                  end
               end
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || out_acc) begin
               rsp_in = '0;
               rsp_in.last = 1'b1;
               rsp_valid_in = 1'b1;
               if (req_ff.operation <= OP_REFRESH) begin
                  rsp_in.slot_out = req_ff.slot;
                  rsp_in.status   = slot_ok ? st_ff : ST_UNARMED;
                  rsp_in.front_changed = slot_ok && wrote_ff && scan_res.found
                                         && scan_res.best == si;
               end else if (req_ff.operation == OP_QUERY) begin
                  if (!scan_res.found) begin
                     rsp_in.wait_ms = TMAX;
                  end else begin
                     rsp_in.slot_out = 4'(scan_res.best);
                     rsp_in.wait_ms  = (req_ff.now_ms >= deadline_ff[scan_res.best]) ? '0
                                       : deadline_ff[scan_res.best] - req_ff.now_ms;
                  end
               end else if (req_ff.operation == OP_COLLECT) begin
                  if (pend_ff) begin
                     rsp_in.status   = ST_EXPIRED;
                     rsp_in.slot_out = 4'(pend_slot_ff);
                  end else begin
                     rsp_in.status = ST_NONE;
                  end
               end
               // collect frees non-recurring picked slots now
               if (req_ff.operation == OP_COLLECT) begin
                  armed_in = armed_ff & ~(taken_ff & ~recurring_ff);
                  rsp_in.any_pending = |armed_in;
               end else begin
                  rsp_in.any_pending = |armed_ff;
               end
            end
         end
         default: ;
      endcase
   end

   // slot payload writes
   always_ff @(posedge clock) begin
      if (state_ff == S_EXEC && req_ff.operation <= OP_REFRESH && slot_ok) begin
         unique case (op_type'(req_ff.operation))
            OP_ADD: begin
               interval_ff[si]  <= per;
               recurring_ff[si] <= req_ff.repeat_flag;
               deadline_ff[si]  <= sat_add(req_ff.now_ms, per);
            end
            OP_RESET: begin
               if (armed_ff[si]) begin
                  interval_ff[si] <= per;
                  deadline_ff[si] <= sat_add(req_ff.start_at_now ? req_ff.now_ms : old_start,
                                             per);
               end
            end
            OP_REFRESH: begin
               if (recurring_ff[si])
                  deadline_ff[si] <= sat_add(req_ff.now_ms, interval_ff[si]);
            end
            default: ;
         endcase
      end
      // re-arm a recurring expired slot as it is picked; taken slots drop out of
      // later scans, so the new deadline cannot disturb the order
      if (state_ff == S_EMIT && req_ff.operation == OP_COLLECT && (!rsp_valid_ff || out_acc)
          && scan_res.found && recurring_ff[scan_res.best])
         deadline_ff[scan_res.best] <= sat_add(req_ff.now_ms, interval_ff[scan_res.best]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         armed_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         armed_ff     <= armed_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
      end
      if (in_acc) req_ff <= req_data;
      rsp_ff       <= rsp_in;
      taken_ff     <= taken_in;
      cnt_ff       <= cnt_in;
      pend_slot_ff <= pend_slot_in;
      wrote_ff     <= wrote_in;
      st_ff        <= st_in;
      keep_ff      <= keep_in;
   end

   `ASSERT_CLK(a_idle_ready, clock, reset, (state_ff == S_IDLE) == !req_stall, "stall mismatch")
   `ASSERT_NEXT(a_accept_exec, clock, reset, in_acc, state_ff == S_EXEC, "no exec after accept")
   `ASSERT_CLK(a_taken_armed, clock, reset, (taken_ff & ~armed_ff) == '0 || state_ff == S_IDLE, "taken slot not armed")

endmodule
